// ----- rtl/core/awd_pkg.sv -----
// Shared constants and types for the anagram window detector.
package awd_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int ALPHABET    = 26;

  localparam int SYM_W   = 5;
  localparam int COUNT_W = $clog2(MAX_PATTERN + 1);
  localparam int RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int DIFF_W  = $clog2(ALPHABET + 1);

  // Item kinds carried on the action field.
  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_TEXT    = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [RING_AW-1:0] ring_addr_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [DIFF_W-1:0]  diff_t;

  // Per-letter commands for one processed item.
  typedef struct packed {
    logic clear_pattern;
    logic load;
    logic clear_window;
    logic inc;
    logic dec;
  } cell_ctrl_t;

  // Per-letter status for the same item.
  typedef struct packed {
    logic new_letter;
    logic enter;
    logic leave;
  } cell_stat_t;

endpackage

// ----- rtl/core/awd_letter_cell.sv -----
// One letter's pattern count and window count, with equality tracking.
module awd_letter_cell
  import awd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  output cell_stat_t stat
);

  count_t pattern_count;
  count_t pattern_count_next;
  count_t pattern_eff;
  count_t window_count;
  count_t window_count_next;

  always_comb begin
    pattern_eff        = ctrl.clear_pattern ? '0 : pattern_count;
    pattern_count_next = ctrl.load ? count_t'(pattern_eff + 1'b1) : pattern_eff;

    if (ctrl.clear_window) begin
      window_count_next = '0;
    end else if (ctrl.inc && !ctrl.dec) begin
      window_count_next = count_t'(window_count + 1'b1);
    end else if (ctrl.dec && !ctrl.inc && (window_count != '0)) begin
      window_count_next = count_t'(window_count - 1'b1);
    end else begin
      window_count_next = window_count;
    end

    stat.new_letter = ctrl.load && (pattern_eff == '0);
    // Only meaningful on text items, where the pattern count holds still.
    stat.leave = (window_count == pattern_count) && (window_count_next != pattern_count);
    stat.enter = (window_count != pattern_count) && (window_count_next == pattern_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count <= '0;
      window_count  <= '0;
    end else begin
      pattern_count <= pattern_count_next;
      window_count  <= window_count_next;
    end
  end

endmodule

// ----- rtl/core/awd_history_ring.sv -----
// History ring of recent text letters, one write and one registered read per cycle.
module awd_history_ring
  import awd_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  ring_addr_t wr_addr,
  input  sym_t       wr_data,
  input  logic       rd_en,
  input  ring_addr_t rd_addr,
  output sym_t       rd_data
);

  sym_t mem [MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Pass the new letter straight through when it lands on the address being read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ----- rtl/core/anagram_window_detector.sv -----
// Sliding-window anagram search: pattern load, text scan and result registers.
// Each accepted item passes through the input register and then the result register.
// Throughput: one item per cycle; the input register and the result register each
//   hold one item, so while a result waits the input can still take one item, then stalls.
// Reset (rst, synchronous): empties both registers, clears pattern and window counts,
//   pattern length, window fill, ring pointer, differing count and the found flag.
module anagram_window_detector
  import awd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [4:0] symbol,
  input  logic       new_pattern,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       match,
  output logic       found_any,
  output logic       pattern_overflow
);

  // Input register
  logic in_full;
  logic act_r;
  sym_t sym_r;
  logic fresh_r;

  // Scan state
  count_t     pattern_length;
  count_t     window_fill;
  ring_addr_t ring_pointer;
  diff_t      differing_letters;
  diff_t      nonzero_letters;
  logic       found_flag;

  count_t     pattern_length_next;
  count_t     window_fill_next;
  ring_addr_t ring_pointer_next;
  diff_t      differing_letters_next;
  diff_t      nonzero_letters_next;
  logic       found_flag_next;

  logic step;
  logic sym_ok;
  logic clear_pattern;
  logic clear_window;
  logic add;
  logic text_go;
  logic evict;
  logic overflow_now;
  logic match_now;
  count_t plen_eff;
  sym_t   old_sym;
  ring_addr_t rd_addr;
  logic [COUNT_W:0] rp_ext;
  logic [COUNT_W:0] rd_wide;
  logic [DIFF_W:0]  diff_wide;

  cell_ctrl_t ctrl [ALPHABET];
  cell_stat_t stat [ALPHABET];
  logic [ALPHABET-1:0] new_vec;
  logic [ALPHABET-1:0] sym_enter_vec;
  logic [ALPHABET-1:0] sym_leave_vec;
  logic [ALPHABET-1:0] old_enter_vec;
  logic [ALPHABET-1:0] old_leave_vec;
  logic sym_enter;
  logic sym_leave;
  logic old_enter;
  logic old_leave;

  function automatic ring_addr_t ring_address_inc(input ring_addr_t a);
    ring_address_inc = ring_addr_t'(a + 1'b1);
  endfunction

  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r   <= action;
      sym_r   <= symbol;
      fresh_r <= new_pattern;
    end
  end

  always_comb begin
    sym_ok        = int'(sym_r) < ALPHABET;
    clear_pattern = step && (act_r == ACT_PATTERN) && fresh_r;
    plen_eff      = clear_pattern ? '0 : pattern_length;
    overflow_now  = step && (act_r == ACT_PATTERN) && sym_ok
                 && (int'(plen_eff) >= MAX_PATTERN);
    add           = step && (act_r == ACT_PATTERN) && sym_ok
                 && (int'(plen_eff) < MAX_PATTERN);
    text_go       = step && (act_r == ACT_TEXT) && (pattern_length != '0) && sym_ok;
    clear_window  = step && ((act_r == ACT_PATTERN) || ((pattern_length != '0) && !sym_ok));
    evict         = text_go && (window_fill >= pattern_length);
  end

  // Letter cell commands
  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      ctrl[i].clear_pattern = clear_pattern;
      ctrl[i].load          = add && (int'(sym_r) == i);
      ctrl[i].clear_window  = clear_window;
      ctrl[i].inc           = text_go && (int'(sym_r) == i);
      ctrl[i].dec           = evict && (int'(old_sym) == i);
    end
  end

  for (genvar g = 0; g < ALPHABET; g++) begin : g_cell
    awd_letter_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl[g]),
      .stat (stat[g])
    );
  end

  // At most one incremented and one decremented cell change: pick out their flags.
  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      new_vec[i]       = stat[i].new_letter;
      sym_enter_vec[i] = stat[i].enter && ctrl[i].inc;
      sym_leave_vec[i] = stat[i].leave && ctrl[i].inc;
      old_enter_vec[i] = stat[i].enter && ctrl[i].dec && !ctrl[i].inc;
      old_leave_vec[i] = stat[i].leave && ctrl[i].dec && !ctrl[i].inc;
    end
    sym_enter = |sym_enter_vec;
    sym_leave = |sym_leave_vec;
    old_enter = |old_enter_vec;
    old_leave = |old_leave_vec;
  end

  always_comb begin
    pattern_length_next  = count_t'(plen_eff + count_t'(add));
    nonzero_letters_next = diff_t'((clear_pattern ? '0 : nonzero_letters) + diff_t'(|new_vec));

    if (clear_window) begin
      window_fill_next = '0;
    end else if (text_go && !evict) begin
      window_fill_next = count_t'(window_fill + 1'b1);
    end else begin
      window_fill_next = window_fill;
    end

    if (clear_window) begin
      ring_pointer_next = '0;
    end else if (text_go) begin
      ring_pointer_next = (int'(ring_pointer) == MAX_PATTERN - 1) ? '0
                        : ring_address_inc(ring_pointer);
    end else begin
      ring_pointer_next = ring_pointer;
    end

    diff_wide = {1'b0, differing_letters} + (DIFF_W+1)'(sym_leave) + (DIFF_W+1)'(old_leave)
              - (DIFF_W+1)'(sym_enter) - (DIFF_W+1)'(old_enter);
    if (clear_window) begin
      differing_letters_next = nonzero_letters_next;
    end else if (text_go) begin
      differing_letters_next = diff_wide[DIFF_W-1:0];
    end else begin
      differing_letters_next = differing_letters;
    end

    match_now       = text_go && (window_fill_next == pattern_length)
                   && (differing_letters_next == '0);
    found_flag_next = clear_pattern ? 1'b0 : (found_flag || match_now);

    // Oldest letter of the window the next item will see.
    rp_ext = (COUNT_W+1)'(ring_pointer_next);
    if (rp_ext >= (COUNT_W+1)'(pattern_length_next)) begin
      rd_wide = rp_ext - (COUNT_W+1)'(pattern_length_next);
    end else begin
      rd_wide = rp_ext + (COUNT_W+1)'(MAX_PATTERN) - (COUNT_W+1)'(pattern_length_next);
    end
    rd_addr = rd_wide[RING_AW-1:0];
  end

  awd_history_ring u_ring (
    .clk     (clk),
    .wr_en   (text_go),
    .wr_addr (ring_pointer),
    .wr_data (sym_r),
    .rd_en   (step),
    .rd_addr (rd_addr),
    .rd_data (old_sym)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length    <= '0;
      window_fill       <= '0;
      ring_pointer      <= '0;
      differing_letters <= '0;
      nonzero_letters   <= '0;
      found_flag        <= 1'b0;
    end else begin
      pattern_length    <= pattern_length_next;
      window_fill       <= window_fill_next;
      ring_pointer      <= ring_pointer_next;
      differing_letters <= differing_letters_next;
      nonzero_letters   <= nonzero_letters_next;
      found_flag        <= found_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      match            <= match_now;
      found_any        <= found_flag_next;
      pattern_overflow <= overflow_now;
    end
  end

endmodule
